// ===== src/video_slot_gap_filler_defines.svh =====
`ifndef VIDEO_SLOT_GAP_FILLER_DEFINES_SVH
`define VIDEO_SLOT_GAP_FILLER_DEFINES_SVH

// same-cycle implication
`define VSGF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VSGF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/vsgf_pkg.sv =====
package vsgf_pkg;

	localparam int PTS_W     = 64;
	localparam int IDENT_W   = 32;
	localparam int INTV_W    = 32;
	localparam int SLOT_W    = 32;
	localparam int MAX_GAP_DEF = 64;
	localparam int QDEPTH    = 2;

	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	// register select is paddr[2]
	localparam logic REG_FRAME_INTERVAL = 1'b0;

	typedef enum logic [2:0] {
		STS_OK            = 3'd0,
		STS_BAD_INTERVAL  = 3'd1,
		STS_NON_MONOTONIC = 3'd2,
		STS_UNALIGNED     = 3'd3,
		STS_GAP_TOO_LARGE = 3'd4
	} vsgf_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} vsgf_state_t;

	typedef struct packed {
		logic               operation;
		logic [PTS_W-1:0]   frame_pts;
		logic [IDENT_W-1:0] frame_ident;
	} vsgf_item_t;

	typedef struct packed {
		vsgf_status_t       status;
		logic               slot_valid;
		logic [SLOT_W-1:0]  slot_number;
		logic [PTS_W-1:0]   slot_pts;
		logic [IDENT_W-1:0] source_ident;
		logic [PTS_W-1:0]   source_pts;
		logic               repeated;
		logic               last;
	} vsgf_result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} vsgf_div_stat_t;

endpackage

// ===== src/video_slot_gap_filler.sv =====
// channel  dir  handshake                 payload
// s_*      in   s_tvalid / s_tready       s_tdata, s_tuser
// m_*      out  m_tvalid / m_tready       m_tdata, m_tuser, m_tlast
// apb      in   psel & penable & pwrite   paddr, pwdata -> prdata
//
// Clear produces no result. Zero interval, first frame or non-monotonic: one result.
// Aligned later frame: bit-serial 64/32 divide, then one slot per cycle unless the output stalls.
// Input queue of two items lets the front accept while the back divides or emits.
// Results wait in the output register while m_tready is low; the back stalls, and
// s_tready drops once the two-entry queue is full.
// arst_n clears history, slot counter, queue and frame_interval.
module video_slot_gap_filler
	import vsgf_pkg::*;
#(
	parameter int MaxGap = MAX_GAP_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // frame_pts, frame_ident
	input  logic [0:0]   s_tuser,  // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,  // slot_number, slot_pts, source_ident, source_pts
	output logic [4:0]   m_tuser,  // status, slot_valid, repeated
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [INTV_W-1:0] frame_interval_q;
	vsgf_item_t        push_item;
	vsgf_item_t        item;
	logic              item_valid;
	logic              q_full;
	logic              pop;
	logic              div_start;
	logic [PTS_W-1:0]  div_dividend;
	vsgf_div_stat_t    div_stat;
	logic [PTS_W-1:0]  div_quotient;
	logic [INTV_W-1:0] div_remainder;
	vsgf_result_t      res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAME_INTERVAL) ? frame_interval_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_interval_q <= '0;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == REG_FRAME_INTERVAL) begin
			frame_interval_q <= pwdata;
		end
	end

	assign push_item.operation   = s_tuser[0];
	assign push_item.frame_pts   = s_tdata[63:0];
	assign push_item.frame_ident = s_tdata[95:64];
	assign s_tready              = !q_full;

	vsgf_in_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_tvalid),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.item_valid (item_valid),
		.item       (item)
	);

	vsgf_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (frame_interval_q),
		.stat      (div_stat),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	vsgf_back #(
		.MaxGap (MaxGap)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_interval (frame_interval_q),
		.item_valid     (item_valid),
		.item           (item),
		.pop            (pop),
		.div_start      (div_start),
		.div_dividend   (div_dividend),
		.div_stat       (div_stat),
		.div_quotient   (div_quotient),
		.div_remainder  (div_remainder),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_result     (res)
	);

	assign m_tdata = {res.source_pts, res.source_ident, res.slot_pts, res.slot_number};
	assign m_tuser = {res.repeated, res.slot_valid, res.status};
	assign m_tlast = res.last;

endmodule

// ===== src/vsgf_in_queue.sv =====
module vsgf_in_queue
	import vsgf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  vsgf_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       item_valid,
	output vsgf_item_t item
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	vsgf_item_t      entry_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == CW'(QDEPTH));
	assign item_valid = (count_q != '0);
	assign item       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== src/vsgf_divider.sv =====
module vsgf_divider
	import vsgf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PTS_W-1:0]  dividend,
	input  logic [INTV_W-1:0] divisor,
	output vsgf_div_stat_t    stat,
	output logic [PTS_W-1:0]  quotient,
	output logic [INTV_W-1:0] remainder
);

	localparam int CNT_W = $clog2(PTS_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PTS_W-1:0]  dq_q;
	logic [INTV_W-1:0] rem_q;
	logic [INTV_W:0]   shifted;
	logic [INTV_W:0]   diff;
	logic              ge;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, dq_q[PTS_W-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign ge      = (shifted >= {1'b0, divisor});

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(PTS_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[PTS_W-2:0], ge};
			rem_q <= ge ? diff[INTV_W-1:0] : shifted[INTV_W-1:0];
		end
	end

endmodule

// ===== src/vsgf_back.sv =====
module vsgf_back
	import vsgf_pkg::*;
#(
	parameter int MaxGap = MAX_GAP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [INTV_W-1:0] frame_interval,
	input  logic              item_valid,
	input  vsgf_item_t        item,
	output logic              pop,
	output logic              div_start,
	output logic [PTS_W-1:0]  div_dividend,
	input  vsgf_div_stat_t    div_stat,
	input  logic [PTS_W-1:0]  div_quotient,
	input  logic [INTV_W-1:0] div_remainder,
	input  logic              out_ready,
	output logic              out_valid,
	output vsgf_result_t      out_result
);

	localparam int GW = $clog2(MaxGap + 1);

	vsgf_state_t        state_q, state_d;
	logic               have_prev_q;
	logic [PTS_W-1:0]   prev_pts_q;
	logic [IDENT_W-1:0] prev_ident_q;
	logic [SLOT_W-1:0]  next_slot_q;
	logic [PTS_W-1:0]   cur_pts_q;
	logic [IDENT_W-1:0] cur_ident_q;
	logic [GW-1:0]      elapsed_q;
	logic [GW-1:0]      off_q;
	logic [PTS_W-1:0]   acc_q;
	logic               out_valid_q;
	vsgf_result_t       out_q;

	logic               out_free;
	logic               load;
	vsgf_result_t       res_d;
	logic               do_clear;
	logic               do_first;
	logic               go_emit;
	logic               emit_step;
	logic               emit_final;
	logic [PTS_W-1:0]   slot_limit;

	assign out_free     = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_result   = out_q;
	assign div_dividend = item.frame_pts - prev_pts_q;
	assign slot_limit   = PTS_W'({SLOT_W{1'b1}} - next_slot_q);

	always_comb begin
		state_d          = state_q;
		pop              = 1'b0;
		div_start        = 1'b0;
		load             = 1'b0;
		do_clear         = 1'b0;
		do_first         = 1'b0;
		go_emit          = 1'b0;
		emit_step        = 1'b0;
		emit_final       = 1'b0;
		res_d            = '0;
		res_d.status     = STS_OK;
		res_d.last       = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && (item.operation == OP_CLEAR || out_free)) begin
					pop = 1'b1;
					if (item.operation == OP_CLEAR) begin
						do_clear = 1'b1;
					end else if (frame_interval == '0) begin
						load         = 1'b1;
						res_d.status = STS_BAD_INTERVAL;
					end else if (!have_prev_q) begin
						load               = 1'b1;
						do_first           = 1'b1;
						res_d.slot_valid   = 1'b1;
						res_d.slot_number  = next_slot_q;
						res_d.slot_pts     = item.frame_pts;
						res_d.source_ident = item.frame_ident;
						res_d.source_pts   = item.frame_pts;
					end else if (item.frame_pts <= prev_pts_q) begin
						load         = 1'b1;
						res_d.status = STS_NON_MONOTONIC;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done && out_free) begin
					if (div_remainder != '0 || div_quotient == '0 ||
							div_quotient >= slot_limit) begin
						load         = 1'b1;
						res_d.status = STS_UNALIGNED;
						state_d      = ST_IDLE;
					end else if (div_quotient > PTS_W'(MaxGap)) begin
						load         = 1'b1;
						res_d.status = STS_GAP_TOO_LARGE;
						state_d      = ST_IDLE;
					end else begin
						go_emit = 1'b1;
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load              = 1'b1;
					emit_step         = 1'b1;
					res_d.slot_valid  = 1'b1;
					res_d.slot_number = next_slot_q;
					if (off_q == elapsed_q) begin
						emit_final         = 1'b1;
						res_d.slot_pts     = cur_pts_q;
						res_d.source_ident = cur_ident_q;
						res_d.source_pts   = cur_pts_q;
						state_d            = ST_IDLE;
					end else begin
						res_d.slot_pts     = acc_q;
						res_d.source_ident = prev_ident_q;
						res_d.source_pts   = prev_pts_q;
						res_d.repeated     = 1'b1;
						res_d.last         = 1'b0;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q  <= 1'b0;
			prev_pts_q   <= '0;
			prev_ident_q <= '0;
			next_slot_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_clear) begin
				have_prev_q <= 1'b0;
				next_slot_q <= '0;
			end else if (load && res_d.slot_valid) begin
				next_slot_q <= next_slot_q + 1'b1;
			end
			if (do_first) begin
				have_prev_q  <= 1'b1;
				prev_pts_q   <= item.frame_pts;
				prev_ident_q <= item.frame_ident;
			end else if (emit_final) begin
				prev_pts_q   <= cur_pts_q;
				prev_ident_q <= cur_ident_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res_d;
		end
		if (div_start) begin
			cur_pts_q   <= item.frame_pts;
			cur_ident_q <= item.frame_ident;
		end
		if (go_emit) begin
			elapsed_q <= div_quotient[GW-1:0];
			off_q     <= GW'(1);
			acc_q     <= prev_pts_q + PTS_W'(frame_interval);
		end else if (emit_step) begin
			off_q <= off_q + 1'b1;
			acc_q <= acc_q + PTS_W'(frame_interval);
		end
	end

endmodule

// ===== src/vsgf_checker.sv =====
`include "video_slot_gap_filler_defines.svh"

module vsgf_checker
	import vsgf_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [191:0] m_tdata,
	input logic [4:0]   m_tuser,
	input logic         m_tlast
);

	logic         stalled;
	logic [197:0] m_word;
	logic         out_noslot;
	logic         out_err;
	logic         out_rep;

	assign stalled    = m_tvalid && !m_tready;
	assign m_word     = {m_tlast, m_tuser, m_tdata};
	assign out_noslot = m_tvalid && !m_tuser[3];
	assign out_err    = m_tvalid && (m_tuser[2:0] != STS_OK);
	assign out_rep    = m_tvalid && m_tuser[4];

	`VSGF_ASSERT_NXT(a_out_hold, clk, arst_n, stalled, m_tvalid && $stable(m_word), "output not held")
	`VSGF_ASSERT_IMP(a_err_last, clk, arst_n, out_noslot, m_tlast, "status result not last")
	`VSGF_ASSERT_IMP(a_err_noslot, clk, arst_n, out_err, !m_tuser[3] && !m_tuser[4], "error has slot")
	`VSGF_ASSERT_IMP(a_rep_notlast, clk, arst_n, out_rep, !m_tlast && m_tuser[3], "repeat marked last")

endmodule

bind video_slot_gap_filler vsgf_checker u_checker (.*);

// ===== test/slot_timeline_checker.sv =====
`timescale 1ns / 100ps

module slot_timeline_checker
	import vsgf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [95:0]  s_tdata,  // frame_pts, frame_ident
	input  logic [0:0]   s_tuser,  // operation
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [191:0] m_tdata,  // slot_number, slot_pts, source_ident, source_pts
	input  logic [4:0]   m_tuser,  // status, slot_valid, repeated
	input  logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           mismatches,
	output int           outstanding
);

	localparam int PRINT_CAP = 40;

	logic [INTV_W-1:0]  tl_interval;
	logic               tl_have_prev;
	logic [PTS_W-1:0]   tl_prev_pts;
	logic [IDENT_W-1:0] tl_prev_ident;
	logic [SLOT_W-1:0]  tl_next_slot;
	vsgf_result_t       pending_slots[$];
	int                 fail_tally = 0;
	int                 queued = 0;

	assign mismatches  = fail_tally;
	assign outstanding = queued;

	function automatic vsgf_result_t status_only(input vsgf_status_t code);
		vsgf_result_t r;
		r = '0;
		r.status = code;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic vsgf_result_t slot_entry(input logic [SLOT_W-1:0] num,
			input logic [PTS_W-1:0] spts, input logic [IDENT_W-1:0] sid,
			input logic [PTS_W-1:0] srcpts, input logic rep, input logic fin);
		vsgf_result_t r;
		r.status       = STS_OK;
		r.slot_valid   = 1'b1;
		r.slot_number  = num;
		r.slot_pts     = spts;
		r.source_ident = sid;
		r.source_pts   = srcpts;
		r.repeated     = rep;
		r.last         = fin;
		return r;
	endfunction

	task automatic report(input string msg);
		if (fail_tally < PRINT_CAP)
			$display("%0t: %s", $time, msg);
		fail_tally++;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (want !== seen)
			report($sformatf("%s mismatch: expected %0h, got %0h", name, want, seen));
	endtask

	task automatic queue_expected(input vsgf_result_t r);
		pending_slots.insert(pending_slots.size(), r);
	endtask

	// fill-in slots for a frame, one status result on error, or nothing on a clear
	task automatic predict_frame(input vsgf_item_t fr);
		logic [PTS_W-1:0] step;
		logic [PTS_W-1:0] delta;
		logic [PTS_W-1:0] elapsed;
		logic [PTS_W-1:0] off;
		step = {32'h0, tl_interval};
		if (fr.operation == OP_CLEAR) begin
			tl_have_prev = 1'b0;
			tl_next_slot = '0;
		end else if (tl_interval == '0) begin
			queue_expected(status_only(STS_BAD_INTERVAL));
		end else if (!tl_have_prev) begin
			queue_expected(slot_entry(tl_next_slot, fr.frame_pts, fr.frame_ident,
				fr.frame_pts, 1'b0, 1'b1));
			tl_next_slot++;
			tl_have_prev  = 1'b1;
			tl_prev_pts   = fr.frame_pts;
			tl_prev_ident = fr.frame_ident;
		end else if (fr.frame_pts <= tl_prev_pts) begin
			queue_expected(status_only(STS_NON_MONOTONIC));
		end else begin
			delta   = fr.frame_pts - tl_prev_pts;
			elapsed = delta / step;
			if (delta % step != 0 || elapsed == 0 ||
					elapsed >= {32'h0, 32'hFFFF_FFFF - tl_next_slot}) begin
				queue_expected(status_only(STS_UNALIGNED));
			end else if (elapsed > MAX_GAP_DEF) begin
				queue_expected(status_only(STS_GAP_TOO_LARGE));
			end else begin
				for (off = 1; off < elapsed; off++) begin
					queue_expected(slot_entry(tl_next_slot, tl_prev_pts + off * step,
						tl_prev_ident, tl_prev_pts, 1'b1, 1'b0));
					tl_next_slot++;
				end
				queue_expected(slot_entry(tl_next_slot, fr.frame_pts, fr.frame_ident,
					fr.frame_pts, 1'b0, 1'b1));
				tl_next_slot++;
				tl_prev_pts   = fr.frame_pts;
				tl_prev_ident = fr.frame_ident;
			end
		end
	endtask

	task automatic check_slot(input vsgf_result_t got);
		vsgf_result_t want;
		if (pending_slots.size() == 0) begin
			report($sformatf("result transfer with none expected, slot %0h", got.slot_number));
		end else begin
			want = pending_slots.pop_front();
			check_field("status", want.status, got.status);
			check_field("slot_valid", want.slot_valid, got.slot_valid);
			check_field("slot_number", want.slot_number, got.slot_number);
			check_field("slot_pts", want.slot_pts, got.slot_pts);
			check_field("source_ident", want.source_ident, got.source_ident);
			check_field("source_pts", want.source_pts, got.source_pts);
			check_field("repeated", want.repeated, got.repeated);
			check_field("last", want.last, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vsgf_result_t seen;
		vsgf_item_t   offered;
		if (!arst_n) begin
			tl_interval   = '0;
			tl_have_prev  = 1'b0;
			tl_prev_pts   = '0;
			tl_prev_ident = '0;
			tl_next_slot  = '0;
			pending_slots.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == {REG_FRAME_INTERVAL, 2'b00})
				tl_interval = pwdata;
			if (m_tvalid && m_tready) begin
				seen.status       = vsgf_status_t'(m_tuser[2:0]);
				seen.slot_valid   = m_tuser[3];
				seen.repeated     = m_tuser[4];
				seen.slot_number  = m_tdata[31:0];
				seen.slot_pts     = m_tdata[95:32];
				seen.source_ident = m_tdata[127:96];
				seen.source_pts   = m_tdata[191:128];
				seen.last         = m_tlast;
				check_slot(seen);
			end
			if (s_tvalid && s_tready) begin
				offered.operation   = s_tuser[0];
				offered.frame_pts   = s_tdata[63:0];
				offered.frame_ident = s_tdata[95:64];
				predict_frame(offered);
			end
		end
		queued = pending_slots.size();
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import vsgf_pkg::*;

	localparam int          SETTLE_CYCLES = 200;
	localparam int          LONG_HOLD     = 400;
	localparam int          PHASE_ITEMS   = 70;
	localparam logic [63:0] BIG_STEP      = 64'hFFFF_FFFF;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;  // frame_pts, frame_ident
	logic [0:0]   s_tuser;  // operation
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;  // slot_number, slot_pts, source_ident, source_pts
	logic [4:0]   m_tuser;  // status, slot_valid, repeated
	logic         m_tlast;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	int           mismatches;
	int           outstanding;

	logic         hold_req = 1'b0;
	int           burst_left = 0;
	logic [31:0]  cur_interval;
	logic         have_base;
	logic [63:0]  base_pts;

	video_slot_gap_filler uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	slot_timeline_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready), .mismatches(mismatches), .outstanding(outstanding)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	// sink: short random stalls, ready stretches, one long hold-off on request
	initial begin
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	task automatic write_interval(input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_FRAME_INTERVAL, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic push_frame(input logic op, input logic [63:0] pts, input logic [31:0] ident);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 10);
		end
		burst_left--;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (!s_tvalid)
			s_tvalid <= 1'b1;
		s_tdata <= {ident, pts};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic halt_and_drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_frame();
		int          pick;
		logic [63:0] pts;
		logic [63:0] step;
		logic [31:0] ident;
		pick  = $urandom_range(0, 99);
		ident = $urandom;
		step  = {32'h0, cur_interval};
		if (pick < 5) begin
			push_frame(OP_CLEAR, {$urandom, $urandom}, ident);
			have_base = 1'b0;
		end else if (!have_base) begin
			pts = {$urandom, $urandom};
			if (&pts[63:48])
				pts[48] = 1'b0;
			push_frame(OP_OBSERVE, pts, ident);
			have_base = (cur_interval != 0);
			base_pts  = pts;
		end else if (pick < 78) begin
			pts = base_pts + step * (($urandom_range(0, 7) == 0) ?
				$urandom_range(5, MAX_GAP_DEF) : $urandom_range(1, 4));
			push_frame(OP_OBSERVE, pts, ident);
			base_pts = pts;
		end else begin
			case ($urandom_range(0, 4))
				0: pts = base_pts - $urandom_range(0, 3);
				1: pts = base_pts + step * $urandom_range(1, 8) +
					((cur_interval > 1) ? $urandom_range(1, cur_interval - 1) : 0);
				2: pts = base_pts + step * $urandom_range(MAX_GAP_DEF + 1, 300);
				3: pts = base_pts + step * {$urandom_range(1, 3), 32'h0};
				default: pts = {$urandom, $urandom};
			endcase
			push_frame(OP_OBSERVE, pts, ident);
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		have_base = 1'b0;
		base_pts  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero interval rejects every frame
		write_interval(32'h0);
		push_frame(OP_OBSERVE, 64'h0, 32'h0);
		push_frame(OP_OBSERVE, '1, '1);
		push_frame(OP_CLEAR, '1, '1);
		halt_and_drain();

		write_interval(32'h1);
		push_frame(OP_OBSERVE, 64'd0, 32'd0);
		push_frame(OP_OBSERVE, 64'd0, 32'd1);
		push_frame(OP_OBSERVE, 64'd1, 32'hFFFF_FFFF);
		push_frame(OP_OBSERVE, 64'd65, 32'd2);
		push_frame(OP_OBSERVE, 64'd130, 32'd3);
		push_frame(OP_OBSERVE, '1, 32'd4);
		push_frame(OP_OBSERVE, 64'd66, 32'd5);
		push_frame(OP_CLEAR, {$urandom, $urandom}, $urandom);
		push_frame(OP_OBSERVE, '1, '1);
		push_frame(OP_OBSERVE, 64'd5, 32'd6);
		push_frame(OP_CLEAR, '0, '0);
		halt_and_drain();

		write_interval(32'hFFFF_FFFF);
		push_frame(OP_OBSERVE, 64'd0, 32'd7);
		push_frame(OP_OBSERVE, 64'd3 * BIG_STEP, 32'd8);
		push_frame(OP_OBSERVE, 64'd3 * BIG_STEP + 64'd1, 32'd9);
		push_frame(OP_OBSERVE, 64'd68 * BIG_STEP, 32'd10);
		push_frame(OP_OBSERVE, 64'd67 * BIG_STEP, 32'd11);
		halt_and_drain();

		write_interval(32'd1000);
		push_frame(OP_CLEAR, '0, '0);
		push_frame(OP_OBSERVE, 64'h0123_4567_89AB_C000, 32'd12);
		push_frame(OP_OBSERVE, 64'h0123_4567_89AB_C5DC, 32'd13);
		push_frame(OP_OBSERVE, 64'h0123_4567_89AB_C7D0, 32'd14);
		halt_and_drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: cur_interval = $urandom_range(2, 16);
				1: cur_interval = $urandom_range(1000, 50_000_000);
				2: cur_interval = $urandom;
				default: cur_interval = 32'h1;
			endcase
			write_interval(cur_interval);
			push_frame(OP_CLEAR, {$urandom, $urandom}, $urandom);
			have_base = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == 20)
					hold_req = 1'b1;
				random_frame();
			end
			halt_and_drain();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/vsgf_pkg.sv
src/vsgf_in_queue.sv
src/vsgf_divider.sv
src/vsgf_back.sv
src/video_slot_gap_filler.sv
src/vsgf_checker.sv
test/slot_timeline_checker.sv
test/tb.sv
